>>> hdl/rfr_pkg.sv
package rfr_pkg;

  localparam int DEFAULT_STORE_DEPTH = 2048;
  localparam logic [7:0] PREAMBLE = 8'hD3;
  localparam logic [24:0] CRC_POLY = 25'h1864CFB;
  localparam logic [10:0] HDR_CRC_LEN = 11'd6;
  localparam logic [10:0] CRC_LEN = 11'd3;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_NONE   = 2'd3
  } status_code_t;

  typedef enum logic [2:0] {
    OFS_ZERO,
    OFS_ONE,
    OFS_TWO,
    OFS_POP,
    OFS_RX
  } offs_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_POP_RD,
    S_POP_USE,
    S_HUNT,
    S_SCAN_RD,
    S_SCAN_USE,
    S_H1_RD,
    S_H1_USE,
    S_H2_RD,
    S_H2_USE,
    S_CRC_RD,
    S_CRC_USE,
    S_RX_RD,
    S_RX_USE,
    S_CMP
  } state_t;

  typedef struct packed {
    logic [0:0] action;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic [0:0]  last_of_frame;
    logic [0:0]  frame_ready;
    logic [10:0] frame_length;
    logic [11:0] fill_level;
    logic [31:0] discarded_count;
    logic [31:0] crc_error_count;
    logic [31:0] frames_done;
    logic [31:0] frame_bytes_total;
  } out_item_t;

  typedef struct packed {
    logic         latch_in;
    logic         do_push;
    logic         pop_use;
    logic         set_offs;
    offs_sel_t    offs_sel;
    logic         offs_inc;
    logic         drop_hunt;
    logic         crc_clear;
    logic         crc_step;
    logic         set_len_hi;
    logic         set_len;
    logic         rx_shift;
    logic         accept_frame;
    logic         crc_fail;
    logic         set_status;
    status_code_t status;
    logic         out_load;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic full;
    logic pending;
    logic held_zero;
    logic is_pre;
    logic held_lt3;
    logic held_lt_len;
    logic crc_last;
    logic rx_last;
    logic crc_match;
    logic out_valid;
  } stat_t;

  function automatic logic [23:0] crc_byte(logic [23:0] c, logic [7:0] d);
    logic [24:0] x;
    x = {1'b0, c ^ {d, 16'h0000}};
    for (int b = 0; b < 8; b++) begin
      x = {x[23:0], 1'b0};
      if (x[24]) begin
        x = x ^ CRC_POLY;
      end
    end
    return x[23:0];
  endfunction

endpackage

>>> hdl/rfr_ctrl.sv
module rfr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rfr_pkg::stat_t st,
  output rfr_pkg::cmd_t  cmd
);
  import rfr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = !(state == S_IDLE && !st.out_valid);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid && !in_stall) state_next = S_STEP;
      S_STEP:     state_next = (st.action && st.pending) ? S_POP_RD : S_HUNT;
      S_POP_RD:   state_next = S_POP_USE;
      S_POP_USE:  state_next = S_HUNT;
      S_HUNT:     state_next = (st.pending || st.held_zero) ? S_IDLE : S_SCAN_RD;
      S_SCAN_RD:  state_next = S_SCAN_USE;
      S_SCAN_USE: begin
        if (!st.is_pre) state_next = S_HUNT;
        else if (st.held_lt3) state_next = S_IDLE;
        else state_next = S_H1_RD;
      end
      S_H1_RD:    state_next = S_H1_USE;
      S_H1_USE:   state_next = S_H2_RD;
      S_H2_RD:    state_next = S_H2_USE;
      S_H2_USE:   state_next = st.held_lt_len ? S_IDLE : S_CRC_RD;
      S_CRC_RD:   state_next = S_CRC_USE;
      S_CRC_USE:  state_next = st.crc_last ? S_RX_RD : S_CRC_RD;
      S_RX_RD:    state_next = S_RX_USE;
      S_RX_USE:   state_next = st.rx_last ? S_CMP : S_RX_RD;
      S_CMP:      state_next = S_HUNT;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.offs_sel = OFS_ZERO;
    cmd.status = ST_STORED;
    unique case (state)
      S_IDLE: cmd.latch_in = in_valid && !in_stall;
      S_STEP: begin
        if (!st.action) begin
          cmd.set_status = 1'b1;
          cmd.status = st.full ? ST_FULL : ST_STORED;
          cmd.do_push = !st.full;
        end else if (!st.pending) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_NONE;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status = ST_POPPED;
          cmd.set_offs = 1'b1;
          cmd.offs_sel = OFS_POP;
        end
      end
      S_POP_RD: ;
      S_POP_USE: cmd.pop_use = 1'b1;
      S_HUNT: begin
        if (st.pending || st.held_zero) begin
          cmd.out_load = 1'b1;
        end else begin
          cmd.set_offs = 1'b1;
          cmd.offs_sel = OFS_ZERO;
        end
      end
      S_SCAN_RD: ;
      S_SCAN_USE: begin
        if (!st.is_pre) begin
          cmd.drop_hunt = 1'b1;
        end else if (st.held_lt3) begin
          cmd.out_load = 1'b1;
        end else begin
          cmd.set_offs = 1'b1;
          cmd.offs_sel = OFS_ONE;
        end
      end
      S_H1_RD: ;
      S_H1_USE: begin
        cmd.set_len_hi = 1'b1;
        cmd.set_offs = 1'b1;
        cmd.offs_sel = OFS_TWO;
      end
      S_H2_RD: ;
      S_H2_USE: begin
        cmd.set_len = 1'b1;
        if (st.held_lt_len) begin
          cmd.out_load = 1'b1;
        end else begin
          cmd.crc_clear = 1'b1;
          cmd.set_offs = 1'b1;
          cmd.offs_sel = OFS_ZERO;
        end
      end
      S_CRC_RD: ;
      S_CRC_USE: begin
        cmd.crc_step = 1'b1;
        cmd.offs_inc = 1'b1;
      end
      S_RX_RD: ;
      S_RX_USE: begin
        cmd.rx_shift = 1'b1;
        cmd.offs_inc = 1'b1;
      end
      S_CMP: begin
        cmd.accept_frame = st.crc_match;
        cmd.crc_fail = !st.crc_match;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/rfr_datapath.sv
module rfr_datapath #(
  parameter int STORE_DEPTH = rfr_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  rfr_pkg::in_item_t  in_item,
  input  logic               out_stall,
  output logic               out_valid,
  output rfr_pkg::out_item_t out_item,
  input  rfr_pkg::cmd_t      cmd,
  output rfr_pkg::stat_t     st
);
  import rfr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(STORE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] head;
  logic [CW-1:0] held;
  logic [AW-1:0] offs;
  logic          pending;
  logic [10:0]   pending_len;
  logic [10:0]   pop_pos;
  logic [31:0]   drop_tally, crc_fail_tally, frame_tally, frame_byte_tally;
  logic          action;
  logic [7:0]    in_byte;
  logic [1:0]    len_hi;
  logic [10:0]   len;
  logic [23:0]   crc, rx;
  status_code_t  status;
  logic [7:0]    obyte;
  logic          last;
  logic [AW-1:0] rd_addr, wr_addr, head_drop;
  logic [10:0]   len_now;
  logic [10:0]   drop_n;
  logic          do_drop;

  // modular address: both terms below the depth, so one subtract suffices
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign rd_addr = wrap_add(head, offs);
  assign wr_addr = wrap_add(head, held[AW-1:0]);
  assign len_now = HDR_CRC_LEN + {1'b0, len_hi, rd_data};

  always_ff @(posedge clk) begin
    if (cmd.do_push) begin
      mem[wr_addr] <= in_byte;
    end
    rd_data <= mem[rd_addr];
  end

  assign st.action     = action;
  assign st.full       = held >= DEPTH_C;
  assign st.pending    = pending;
  assign st.held_zero  = held == '0;
  assign st.is_pre     = rd_data == PREAMBLE;
  assign st.held_lt3   = held < CW'(CRC_LEN);
  assign st.held_lt_len = held < CW'(len_now);
  assign st.crc_last   = (11'(offs) + 11'd1) == (len - CRC_LEN);
  assign st.rx_last    = 11'(offs) == (len - 11'd1);
  assign st.crc_match  = crc == rx;
  assign st.out_valid  = out_valid;

  // frame release after its final byte, or a single byte on a hunt miss or a CRC failure
  always_comb begin
    do_drop = 1'b0;
    drop_n = 11'd1;
    if (cmd.pop_use && (pop_pos + 11'd1 >= pending_len)) begin
      do_drop = 1'b1;
      drop_n = pending_len;
    end else if (cmd.drop_hunt || cmd.crc_fail) begin
      do_drop = 1'b1;
    end
  end

  assign head_drop = wrap_add(head, AW'(drop_n));

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      held <= '0;
      pending <= 1'b0;
      pending_len <= '0;
      pop_pos <= '0;
      drop_tally <= '0;
      crc_fail_tally <= '0;
      frame_tally <= '0;
      frame_byte_tally <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.do_push) begin
        held <= held + CW'(1);
      end
      if (do_drop) begin
        head <= head_drop;
        held <= held - CW'(drop_n);
      end
      if (cmd.drop_hunt) begin
        drop_tally <= drop_tally + 32'd1;
      end
      if (cmd.crc_fail) begin
        crc_fail_tally <= crc_fail_tally + 32'd1;
      end
      if (cmd.pop_use) begin
        if (pop_pos + 11'd1 >= pending_len) begin
          frame_tally <= frame_tally + 32'd1;
          frame_byte_tally <= frame_byte_tally + 32'(pending_len);
          pending <= 1'b0;
          pending_len <= '0;
          pop_pos <= '0;
        end else begin
          pop_pos <= pop_pos + 11'd1;
        end
      end
      if (cmd.accept_frame) begin
        pending <= 1'b1;
        pending_len <= len;
        pop_pos <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action <= in_item.action;
      in_byte <= in_item.in_byte;
      obyte <= '0;
      last <= 1'b0;
    end
    if (cmd.set_status) begin
      status <= cmd.status;
    end
    if (cmd.pop_use) begin
      obyte <= rd_data;
      last <= pop_pos + 11'd1 >= pending_len;
    end
    if (cmd.set_offs) begin
      case (cmd.offs_sel)
        OFS_ZERO: offs <= '0;
        OFS_ONE:  offs <= AW'(1);
        OFS_TWO:  offs <= AW'(2);
        OFS_POP:  offs <= AW'(pop_pos);
        OFS_RX:   offs <= AW'(len - CRC_LEN);
        default:  offs <= '0;
      endcase
    end else if (cmd.offs_inc) begin
      offs <= offs + AW'(1);
    end
    if (cmd.set_len_hi) begin
      len_hi <= rd_data[1:0];
    end
    if (cmd.set_len) begin
      len <= len_now;
    end
    if (cmd.crc_clear) begin
      crc <= '0;
    end else if (cmd.crc_step) begin
      crc <= crc_byte(crc, rd_data);
    end
    if (cmd.rx_shift) begin
      rx <= {rx[15:0], rd_data};
    end
    if (cmd.out_load) begin
      out_item.status <= status;
      out_item.out_byte <= obyte;
      out_item.last_of_frame <= last;
      out_item.frame_ready <= pending;
      out_item.frame_length <= pending ? pending_len : 11'd0;
      out_item.fill_level <= 12'(held);
      out_item.discarded_count <= drop_tally;
      out_item.crc_error_count <= crc_fail_tally;
      out_item.frames_done <= frame_tally;
      out_item.frame_bytes_total <= frame_byte_tally;
    end
  end

endmodule

>>> hdl/rtcm3_frame_resync_buffer.sv
// RTCM3 deframer with a resynchronizing byte store. Each input transfer either
// pushes a received byte (action 0) or pops the next byte of a validated frame
// (action 1); each gives exactly one result transfer carrying status and the
// running counters. After every step the block hunts for a frame at the head
// of the store: it drops bytes until a 0xD3 preamble, reads the 10-bit length,
// walks a CRC-24Q over header and payload and checks it against the trailing
// three bytes. One item is handled at a time. The store has a single read port
// with registered data, so each byte visited takes a read state and a use state.
// There is no clearing pass: only held bytes are ever read.
module rtcm3_frame_resync_buffer #(
  parameter int STORE_DEPTH = rfr_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rfr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rfr_pkg::out_item_t out_item
);
  import rfr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer: step, then the hunt, then the result register load
  rfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // byte store, pointers, crc unit, counters and result register
  rfr_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
